// ===== rtl/core/u8fg_pkg.sv =====
// u8fg_pkg: shared types and constants for the UTF-8 to font glyph decoder.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package u8fg_pkg;

  typedef logic [7:0] byte_t;

  // Lead bytes that select a mapping.
  localparam byte_t LEAD_LATIN1  = 8'hC2;
  localparam byte_t LEAD_LATIN1S = 8'hC3;
  localparam byte_t LEAD_C4      = 8'hC4;
  localparam byte_t LEAD_C5      = 8'hC5;
  localparam byte_t LEAD_EURO    = 8'h82;
  localparam byte_t LEAD_D0      = 8'hD0;
  localparam byte_t LEAD_D1      = 8'hD1;
  localparam byte_t LEAD_D2      = 8'hD2;

  localparam byte_t LATIN1_OR    = 8'hC0;
  localparam byte_t EURO_IN      = 8'hAC;
  localparam byte_t EURO_GLYPH   = 8'hB6;
  localparam byte_t CYR_UP_OFS   = 8'd17;
  localparam byte_t CYR_UP2_OFS  = 8'd49;
  localparam byte_t CYR_LO_OFS   = 8'd15;

  // Cascade entry points; a later group is tried from every earlier entry.
  typedef logic [2:0] entry_t;
  localparam entry_t ENTRY_PL_A  = 3'd0;
  localparam entry_t ENTRY_PL_B  = 3'd1;
  localparam entry_t ENTRY_EURO  = 3'd2;
  localparam entry_t ENTRY_CYR_U = 3'd3;
  localparam entry_t ENTRY_CYR_L = 3'd4;
  localparam entry_t ENTRY_CYR_X = 3'd5;
  localparam entry_t ENTRY_NONE  = 3'd6;

  // Contents of the input register: the byte and the lead seen before it.
  typedef struct packed {
    byte_t data;
    byte_t lead;
  } s1_t;

endpackage

`default_nettype wire

// ===== rtl/core/u8fg_in_if.sv =====
// u8fg_in_if: valid/ready channel carrying one raw UTF-8 byte.
// Depends on u8fg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface u8fg_in_if;
  logic               valid;
  logic               ready;
  u8fg_pkg::byte_t    in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u8fg_out_if.sv =====
// u8fg_out_if: valid/ready channel carrying one font glyph index.
// Depends on u8fg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface u8fg_out_if;
  logic               valid;
  logic               ready;
  u8fg_pkg::byte_t    glyph;

  modport source (output valid, output glyph, input ready);
  modport sink   (input valid, input glyph, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u8fg_map.sv =====
// u8fg_map: combinational mapping of one byte, given its lead, to a glyph.
// Depends on u8fg_pkg. A zero glyph means no result.
`timescale 1ns / 1ps
`default_nettype none

module u8fg_map (
  input  var u8fg_pkg::s1_t   s1,
  output u8fg_pkg::byte_t     glyph
);

  u8fg_pkg::entry_t entry;
  u8fg_pkg::byte_t  b;
  logic e0, e1, e2, e3, e4, e5;

  assign b = s1.data;

  always_comb begin
    unique case (s1.lead)
      u8fg_pkg::LEAD_C4:   entry = u8fg_pkg::ENTRY_PL_A;
      u8fg_pkg::LEAD_C5:   entry = u8fg_pkg::ENTRY_PL_B;
      u8fg_pkg::LEAD_EURO: entry = u8fg_pkg::ENTRY_EURO;
      u8fg_pkg::LEAD_D0:   entry = u8fg_pkg::ENTRY_CYR_U;
      u8fg_pkg::LEAD_D1:   entry = u8fg_pkg::ENTRY_CYR_L;
      u8fg_pkg::LEAD_D2:   entry = u8fg_pkg::ENTRY_CYR_X;
      default:             entry = u8fg_pkg::ENTRY_NONE;
    endcase
  end

  assign e0 = (entry <= u8fg_pkg::ENTRY_PL_A);
  assign e1 = (entry <= u8fg_pkg::ENTRY_PL_B);
  assign e2 = (entry <= u8fg_pkg::ENTRY_EURO);
  assign e3 = (entry <= u8fg_pkg::ENTRY_CYR_U);
  assign e4 = (entry <= u8fg_pkg::ENTRY_CYR_L);
  assign e5 = (entry <= u8fg_pkg::ENTRY_CYR_X);

  // First matching check in cascade order wins.
  always_comb begin
    if (!b[7]) begin
      glyph = b;
    end else if (s1.lead == u8fg_pkg::LEAD_LATIN1) begin
      glyph = b;
    end else if (s1.lead == u8fg_pkg::LEAD_LATIN1S) begin
      if (b == 8'hB3)      glyph = 8'h6F;
      else if (b == 8'h93) glyph = 8'h4F;
      else                 glyph = b | u8fg_pkg::LATIN1_OR;
    end
    else if (e0 && b == 8'h85) glyph = 8'h61;
    else if (e0 && b == 8'h84) glyph = 8'h41;
    else if (e0 && b == 8'h87) glyph = 8'h63;
    else if (e0 && b == 8'h86) glyph = 8'h43;
    else if (e0 && b == 8'h99) glyph = 8'h65;
    else if (e0 && b == 8'h98) glyph = 8'h45;
    else if (e1 && b == 8'h82) glyph = 8'h6C;
    else if (e1 && b == 8'h81) glyph = 8'h4C;
    else if (e1 && b == 8'h84) glyph = 8'h6E;
    else if (e1 && b == 8'h83) glyph = 8'h4E;
    else if (e1 && b == 8'h9A) glyph = 8'h53;
    else if (e1 && b == 8'hBC) glyph = 8'h7A;
    else if (e1 && b == 8'hBB) glyph = 8'h5A;
    else if (e1 && b == 8'hBA) glyph = 8'h7A;
    else if (e1 && b == 8'hB9) glyph = 8'h5A;
    else if (e1 && b == 8'h9B) glyph = 8'h73;
    else if (e2 && b == u8fg_pkg::EURO_IN) glyph = u8fg_pkg::EURO_GLYPH;
    else if (e3 && b == 8'h81) glyph = 8'h84;
    else if (e3 && b == 8'h84) glyph = 8'hA0;
    else if (e3 && b == 8'h86) glyph = 8'hA1;
    else if (e3 && b == 8'h87) glyph = 8'hEF;
    else if (e3 && b >= 8'h90 && b <= 8'hAF) glyph = b - u8fg_pkg::CYR_UP_OFS;
    else if (e3 && b >= 8'hB0 && b <= 8'hBF) glyph = b - u8fg_pkg::CYR_UP2_OFS;
    else if (e4 && b == 8'h91) glyph = 8'h84;
    else if (e4 && b == 8'h94) glyph = 8'hA0;
    else if (e4 && b == 8'h96) glyph = 8'hA1;
    else if (e4 && b == 8'h97) glyph = 8'hEF;
    else if (e4 && b <= 8'h8F) glyph = b + u8fg_pkg::CYR_LO_OFS;
    else if (e5 && (b == 8'h90 || b == 8'h91)) glyph = 8'h9F;
    else glyph = '0;
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_font_glyph_decoder_core.sv =====
// utf8_to_font_glyph_decoder_core: top level of the UTF-8 to font glyph decoder.
// Depends on u8fg_pkg, u8fg_in_if, u8fg_out_if and u8fg_map.
//
// Usage:
//   in_ch  : one UTF-8 byte per transfer (valid/ready, in_byte).
//   out_ch : one glyph index per transfer (valid/ready, glyph), never zero.
//   Each byte gives zero or one glyph; a byte whose mapping is zero gives none.
//   A byte of 0x80 or more is mapped by the byte of 0x80 or more before it and
//   becomes the new lead; a byte below 0x80 clears the lead and passes as is.
// Path: a byte lands in the input register when it transfers, and the mapping
//   logic loads its glyph into the output register once the output stage is
//   free (out_ch not holding a glyph, or out_ch.ready high).
// Throughput: one byte per cycle while out_ch.ready is high, set by the
//   two-register pipeline with one mapping pass between them.
// Reset (rst_n low, synchronous): both pipeline stages empty, lead cleared.
// Stall: while out_ch.ready is low the glyph is held; the input register
//   still takes one more byte, then in_ch.ready drops until the output moves.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_font_glyph_decoder_core (
  input  wire         clk,
  input  wire         rst_n,
  u8fg_in_if.sink     in_ch,
  u8fg_out_if.source  out_ch
);

  // Lead tracking happens at input transfer time, so order is preserved.
  u8fg_pkg::byte_t lead_r, lead_nxt;
  u8fg_pkg::s1_t   s1_r, s1_nxt;
  logic            s1_valid_r, s1_valid_nxt;
  u8fg_pkg::byte_t glyph_r, glyph_nxt;
  logic            out_valid_r, out_valid_nxt;
  u8fg_pkg::byte_t map_glyph;

  logic in_xfer, s2_free, s1_adv;

  assign s2_free = !out_valid_r || out_ch.ready;
  assign s1_adv  = s1_valid_r && s2_free;
  assign in_ch.ready = !s1_valid_r || s2_free;
  assign in_xfer = in_ch.valid && in_ch.ready;

  u8fg_map u_map (
    .s1    (s1_r),
    .glyph (map_glyph)
  );

  always_comb begin
    lead_nxt     = lead_r;
    s1_nxt       = s1_r;
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      // Capture the byte with the lead it sees, then update the lead.
      s1_nxt.data  = in_ch.in_byte;
      s1_nxt.lead  = lead_r;
      s1_valid_nxt = 1'b1;
      lead_nxt     = in_ch.in_byte[7] ? in_ch.in_byte : '0;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    glyph_nxt     = glyph_r;
    out_valid_nxt = out_valid_r;
    if (s2_free) begin
      // Drop zero glyphs here; they never reach the output.
      glyph_nxt     = map_glyph;
      out_valid_nxt = s1_valid_r && (map_glyph != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lead_r      <= lead_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= s1_nxt;
    glyph_r <= glyph_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.glyph = glyph_r;

  // A glyph offered downstream is never zero.
  a_no_zero_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (glyph_r != '0))
    else $error("zero glyph offered on output");

  // An ASCII byte clears the lead.
  a_ascii_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_ch.in_byte[7]) |=> (lead_r == '0))
    else $error("lead not cleared after ASCII byte");

  // A high byte becomes the lead.
  a_high_sets_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.in_byte[7]) |=> (lead_r == $past(in_ch.in_byte)))
    else $error("lead not updated after high byte");

  // A blocked input stage keeps its contents.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_free) |=> (s1_valid_r && $stable(s1_r)))
    else $error("input stage lost data while blocked");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking bench for utf8_to_font_glyph_decoder_core.
// Drives UTF-8 bytes, predicts each unpinned glyph from its own copy of the lead-byte state.
// Depends on u8fg_pkg, u8fg_in_if, u8fg_out_if and the core.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_BYTES = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 36;

  // One byte as offered on the input channel; where pinned is set the
  // glyph (or its absence) is typed in by hand instead of predicted.
  typedef struct packed {
    u8fg_pkg::byte_t data;
    logic            pinned;
    logic            emits;
    u8fg_pkg::byte_t glyph;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  u8fg_in_if  in_ch ();
  u8fg_out_if out_ch ();

  // Hold every block input at a known value from time zero.
  logic            feed_valid = 1'b0;
  u8fg_pkg::byte_t feed_byte = 8'h00;
  logic            take_ready = 1'b0;
  assign in_ch.valid   = feed_valid;
  assign in_ch.in_byte = feed_byte;
  assign out_ch.ready  = take_ready;

  utf8_to_font_glyph_decoder_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bench state: bytes offered but not yet transferred, glyphs still owed by
  // the block, and the decoder's lead byte as this bench sees it.
  byte_row_t       offered_rows[$];
  u8fg_pkg::byte_t owed_glyphs[$];
  u8fg_pkg::byte_t seen_lead = 8'h00;
  bit              idle_en = 1'b1;
  int              bytes_sent = 0;
  int              glyphs_seen = 0;
  int              fail_count = 0;
  int              cyc = 0;

  u8fg_pkg::byte_t lead_pool[8] = '{u8fg_pkg::LEAD_LATIN1, u8fg_pkg::LEAD_LATIN1S,
                                    u8fg_pkg::LEAD_C4, u8fg_pkg::LEAD_C5,
                                    u8fg_pkg::LEAD_EURO, u8fg_pkg::LEAD_D0,
                                    u8fg_pkg::LEAD_D1, u8fg_pkg::LEAD_D2};

  // Where the fall-through cascade starts for a given lead.
  function automatic u8fg_pkg::entry_t cascade_start(u8fg_pkg::byte_t lead);
    case (lead)
      u8fg_pkg::LEAD_C4:   return u8fg_pkg::ENTRY_PL_A;
      u8fg_pkg::LEAD_C5:   return u8fg_pkg::ENTRY_PL_B;
      u8fg_pkg::LEAD_EURO: return u8fg_pkg::ENTRY_EURO;
      u8fg_pkg::LEAD_D0:   return u8fg_pkg::ENTRY_CYR_U;
      u8fg_pkg::LEAD_D1:   return u8fg_pkg::ENTRY_CYR_L;
      u8fg_pkg::LEAD_D2:   return u8fg_pkg::ENTRY_CYR_X;
      default:             return u8fg_pkg::ENTRY_NONE;
    endcase
  endfunction

  // Glyph for a byte of 0x80 or more given the lead stored before it;
  // zero means the block emits nothing.
  function automatic u8fg_pkg::byte_t glyph_for(u8fg_pkg::byte_t lead,
                                                u8fg_pkg::byte_t b);
    u8fg_pkg::entry_t e;
    e = cascade_start(lead);
    if (lead == u8fg_pkg::LEAD_LATIN1) return b;
    if (lead == u8fg_pkg::LEAD_LATIN1S) begin
      if (b == 8'hB3) return 8'h6F;
      if (b == 8'h93) return 8'h4F;
      return b | u8fg_pkg::LATIN1_OR;
    end
    // Each group is tried from its own entry and from every earlier one;
    // the first hit in cascade order wins.
    if (e <= u8fg_pkg::ENTRY_PL_A) begin
      case (b)
        8'h85: return 8'h61;
        8'h84: return 8'h41;
        8'h87: return 8'h63;
        8'h86: return 8'h43;
        8'h99: return 8'h65;
        8'h98: return 8'h45;
        default: ;
      endcase
    end
    if (e <= u8fg_pkg::ENTRY_PL_B) begin
      case (b)
        8'h82: return 8'h6C;
        8'h81: return 8'h4C;
        8'h84: return 8'h6E;
        8'h83: return 8'h4E;
        8'h9A: return 8'h53;
        8'hBC: return 8'h7A;
        8'hBB: return 8'h5A;
        8'hBA: return 8'h7A;
        8'hB9: return 8'h5A;
        8'h9B: return 8'h73;
        default: ;
      endcase
    end
    if (e <= u8fg_pkg::ENTRY_EURO && b == u8fg_pkg::EURO_IN) return u8fg_pkg::EURO_GLYPH;
    if (e <= u8fg_pkg::ENTRY_CYR_U) begin
      case (b)
        8'h81: return 8'h84;
        8'h84: return 8'hA0;
        8'h86: return 8'hA1;
        8'h87: return 8'hEF;
        default: ;
      endcase
      if (b >= 8'h90 && b <= 8'hAF) return b - u8fg_pkg::CYR_UP_OFS;
      if (b >= 8'hB0 && b <= 8'hBF) return b - u8fg_pkg::CYR_UP2_OFS;
    end
    if (e <= u8fg_pkg::ENTRY_CYR_L) begin
      case (b)
        8'h91: return 8'h84;
        8'h94: return 8'hA0;
        8'h96: return 8'hA1;
        8'h97: return 8'hEF;
        default: ;
      endcase
      if (b >= 8'h80 && b <= 8'h8F) return b + u8fg_pkg::CYR_LO_OFS;
    end
    if (e <= u8fg_pkg::ENTRY_CYR_X && (b == 8'h90 || b == 8'h91)) return 8'h9F;
    return 8'h00;
  endfunction

  // Directed bytes: extremes, the null byte, every mapping group, and a
  // continuation byte acting as lead (0x82 then 0xAC gives the Euro glyph).
  localparam int N_DIRECTED = 24;
  byte_row_t directed_rows[N_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b0, 8'h00},   // null byte right after reset: nothing
    '{8'h7F, 1'b1, 1'b1, 8'h7F},   // top of ASCII passes through
    '{8'h80, 1'b1, 1'b0, 8'h00},   // high byte with no lead: nothing
    '{8'hFF, 1'b1, 1'b0, 8'h00},   // unmapped lead 0x80: nothing
    '{8'hC2, 1'b0, 1'b0, 8'h00},
    '{8'hA9, 1'b1, 1'b1, 8'hA9},   // after 0xC2 the byte passes as is
    '{8'hC3, 1'b0, 1'b0, 8'h00},
    '{8'hB3, 1'b1, 1'b1, 8'h6F},   // o-acute folds to 'o'
    '{8'h41, 1'b1, 1'b1, 8'h41},
    '{8'hC3, 1'b0, 1'b0, 8'h00},
    '{8'h93, 1'b1, 1'b1, 8'h4F},   // O-acute folds to 'O'
    '{8'hC3, 1'b0, 1'b0, 8'h00},
    '{8'hA9, 1'b1, 1'b1, 8'hE9},   // other 0xC3 bytes are ORed with 0xC0
    '{8'hC4, 1'b0, 1'b0, 8'h00},
    '{8'h84, 1'b0, 1'b0, 8'h00},   // first Polish group wins over 'n'
    '{8'hC5, 1'b0, 1'b0, 8'h00},
    '{8'h82, 1'b0, 1'b0, 8'h00},
    '{8'hAC, 1'b1, 1'b1, 8'hB6},   // Euro sign through a continuation lead
    '{8'hD0, 1'b0, 1'b0, 8'h00},
    '{8'hB0, 1'b0, 1'b0, 8'h00},
    '{8'hD1, 1'b0, 1'b0, 8'h00},
    '{8'h8F, 1'b0, 1'b0, 8'h00},
    '{8'hD2, 1'b0, 1'b0, 8'h00},
    '{8'h91, 1'b0, 1'b0, 8'h00}
  };

  // Offer one byte: idle at random first while idling is enabled, then hold valid until the transfer.
  task automatic send_byte(input byte_row_t row);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      feed_valid <= 1'b0;
      @(posedge clk);
    end
    feed_valid <= 1'b1;
    feed_byte  <= row.data;
    offered_rows.push_back(row);
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_free(input u8fg_pkg::byte_t b);
    send_byte('{b, 1'b0, 1'b0, 8'h00});
  endtask

  // Drop valid and wait until every owed glyph has arrived.
  task automatic drain_glyphs();
    feed_valid <= 1'b0;
    @(posedge clk);
    while (owed_glyphs.size() != 0) @(posedge clk);
  endtask

  // Mostly lead + continuation pairs, some three-byte Euro runs, runs of
  // bare continuations, ASCII, and raw noise over the full byte range.
  task automatic send_random(input int count);
    int stop_at;
    int pick;
    int run;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_free(lead_pool[$urandom_range(7)]);
        send_free(u8fg_pkg::byte_t'($urandom_range(8'hBF, 8'h80)));
      end else if (pick < 60) begin
        send_free(8'hE2);
        send_free(u8fg_pkg::LEAD_EURO);
        send_free(($urandom_range(1) == 0) ? u8fg_pkg::EURO_IN
                  : u8fg_pkg::byte_t'($urandom_range(8'hBF, 8'h80)));
      end else if (pick < 70) begin
        run = $urandom_range(4, 2);
        repeat (run) send_free(u8fg_pkg::byte_t'($urandom_range(8'hBF, 8'h80)));
      end else if (pick < 85) begin
        send_free(u8fg_pkg::byte_t'($urandom_range(8'h7F, 8'h00)));
      end else begin
        send_free(u8fg_pkg::byte_t'($urandom_range(8'hFF, 8'h00)));
      end
    end
  endtask

  // Result side: stall at random while idling is enabled.
  always @(posedge clk) begin
    take_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
  end

  // Predict on every input transfer, then check every output transfer
  // against the oldest owed glyph. Both in one block, so order is fixed.
  always @(posedge clk) begin
    byte_row_t       row;
    u8fg_pkg::byte_t predicted;
    u8fg_pkg::byte_t oldest;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        row = offered_rows.pop_front();
        if (in_ch.in_byte < 8'h80) begin
          predicted = in_ch.in_byte;
          seen_lead = 8'h00;
        end else begin
          predicted = glyph_for(seen_lead, in_ch.in_byte);
          seen_lead = in_ch.in_byte;
        end
        if (row.pinned) begin
          if (row.emits) owed_glyphs.push_back(row.glyph);
        end else if (predicted != 8'h00) begin
          owed_glyphs.push_back(predicted);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        glyphs_seen++;
        if (owed_glyphs.size() == 0) begin
          fail_count++;
          $display("%0t: glyph expected none, actual %02h", $time, out_ch.glyph);
        end else begin
          oldest = owed_glyphs.pop_front();
          if (out_ch.glyph !== oldest) begin
            fail_count++;
            $display("%0t: glyph expected %02h, actual %02h", $time, oldest, out_ch.glyph);
          end
        end
      end
    end
  end

  // Hard stop if the handshake ever hangs.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d glyphs still owed", $time, owed_glyphs.size());
      $display("utf8_to_font_glyph_decoder_core: mismatch");
      $finish;
    end
  end

  initial begin
    // Reset once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    drain_glyphs();

    // Random traffic: idling on, then a long stretch at full rate, a full
    // drain, and idling on again to the end.
    send_random(700);
    idle_en = 1'b0;
    send_random(450);
    drain_glyphs();
    idle_en = 1'b1;
    send_random(RANDOM_BYTES - 1150);

    drain_glyphs();
    repeat (8) @(posedge clk);

    if (owed_glyphs.size() != 0) begin
      fail_count++;
      $display("%0t: glyph expected %02h, actual none (%0d missing)", $time,
               owed_glyphs[0], owed_glyphs.size());
    end
    $display("Sent %0d bytes (%0d directed) across all lead groups, checked %0d glyphs.",
             bytes_sent, N_DIRECTED, glyphs_seen);
    if (fail_count == 0) begin
      $display("utf8_to_font_glyph_decoder_core: match");
    end else begin
      $display("utf8_to_font_glyph_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== utf8_to_font_glyph_decoder_core.f =====
rtl/core/u8fg_pkg.sv
rtl/core/u8fg_in_if.sv
rtl/core/u8fg_out_if.sv
rtl/core/u8fg_map.sv
rtl/core/utf8_to_font_glyph_decoder_core.sv
verif/tb.sv
